FILE: rtl/srpg_pkg.sv
// Package for the stepper ramp profile generator: payload structs, state codes,
// register indexes and controller/datapath command types. No dependencies.
package srpg_pkg;

   localparam int unsigned POS_W = 24;

   typedef enum logic [2:0] {
      CSR_F_MIN       = 3'd0,
      CSR_F_MAX       = 3'd1,
      CSR_ACCEL       = 3'd2,
      CSR_TIMER_CLOCK = 3'd3,
      CSR_PRESCALER   = 3'd4
   } csr_index_type;

   localparam logic CMD_MOVE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic              command;
      logic [1:0]        axis;
      logic signed [23:0] target_0;
      logic signed [23:0] target_1;
      logic signed [23:0] target_2;
   } req_type;

   typedef struct packed {
      logic [1:0]         axis_out;
      logic [15:0]        step_period;
      logic               step_valid;
      logic               move_done;
      logic               direction_out;
      logic signed [23:0] position_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SQRT,
      ST_FREQ,
      ST_MUL,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch the accepted item
      logic move;        // apply a move to all axes
      logic sqrt_start;  // set up square root of 2*k*accel
      logic sqrt_step;   // one root bit
      logic freq;        // f = min(f_min + root, f_max)
      logic mul;         // divisor = (prescaler+1)*f*2
      logic div_step;    // one quotient bit
      logic finish;      // form the result, advance the axis
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_move;
      logic no_step;     // out-of-range or finished tick
      logic sqrt_last;
      logic div_last;
   } dp_sts_type;

endpackage

FILE: rtl/srpg_ctrl.sv
// Controller for the stepper ramp profile generator: sequences one item through
// the datapath. Depends on srpg_pkg.
module srpg_ctrl import srpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (sts.is_move || sts.no_step) state_in = ST_FINISH;
            else state_in = ST_SQRT;
         end
         ST_SQRT:   if (sts.sqrt_last) state_in = ST_FREQ;
         ST_FREQ:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (sts.div_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            cmd.move       = sts.is_move;
            cmd.sqrt_start = !sts.is_move && !sts.no_step;
         end
         ST_SQRT:   cmd.sqrt_step = 1'b1;
         ST_FREQ:   cmd.freq = 1'b1;
         ST_MUL:    cmd.mul = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_OUT:    rsp_valid = 1'b1;
         default:   ;
      endcase
   end

endmodule

FILE: rtl/srpg_dp.sv
// Datapath for the stepper ramp profile generator: axis state, serial square
// root, frequency clamp, divisor multiply and serial divider. Depends on srpg_pkg.
module srpg_dp import srpg_pkg::*; #(
   parameter int unsigned AXES     = 3,
   parameter int unsigned MAX_MOVE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   output rsp_type     rsp_data
);

   localparam int unsigned LEN_W = $clog2(MAX_MOVE + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MOVE);
   // 2*k*accel < 2^(LEN_W+17); radicand is 2*RT_W bits, root fits in RT_W bits
   localparam int unsigned RT_W  = (LEN_W + 19) / 2;
   localparam int unsigned RAD_W = 2 * RT_W;
   localparam int unsigned RC_W  = $clog2(RT_W + 1);

   // configuration
   logic [15:0] f_min_ff, f_max_ff, accel_ff, presc_ff;
   logic [31:0] tclk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_min_ff <= 16'd500;
         f_max_ff <= 16'd20000;
         accel_ff <= 16'd2000;
         tclk_ff  <= 32'd72000000;
         presc_ff <= 16'd71;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_F_MIN:       f_min_ff <= csr_data[15:0];
            CSR_F_MAX:       f_max_ff <= csr_data[15:0];
            CSR_ACCEL:       accel_ff <= csr_data[15:0];
            CSR_TIMER_CLOCK: tclk_ff  <= csr_data;
            CSR_PRESCALER:   presc_ff <= csr_data[15:0];
            default:         ;
         endcase
      end
   end

   // axis state
   logic [POS_W-1:0] pos_ff [AXES];
   logic             dir_ff [AXES];
   logic [LEN_W-1:0] len_ff [AXES];
   logic [LEN_W-1:0] idx_ff [AXES];

   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   logic in_range;
   logic [1:0] ax;
   assign ax = req_ff.axis;
   assign in_range = 32'(ax) < AXES;

   logic [POS_W-1:0] cur_pos;
   logic             cur_dir;
   logic [LEN_W-1:0] cur_len, cur_idx;
   always_comb begin
      cur_pos = '0; cur_dir = 1'b0; cur_len = '0; cur_idx = '0;
      for (int a = 0; a < AXES; a++) begin
         if (32'(ax) == a) begin
            cur_pos = pos_ff[a]; cur_dir = dir_ff[a];
            cur_len = len_ff[a]; cur_idx = idx_ff[a];
         end
      end
   end

   assign sts.is_move = req_ff.command == CMD_MOVE;
   assign sts.no_step = !in_range || (cur_idx >= cur_len);

   // per-axis move targets
   function automatic logic [POS_W-1:0] tgt_of(input req_type r, input int a,
                                                input logic [POS_W-1:0] cur);
      logic [POS_W-1:0] t;
      case (a)
         0:       t = r.target_0;
         1:       t = r.target_1;
         2:       t = r.target_2;
         default: t = cur;
      endcase
      return t;
   endfunction

   logic do_step;
   assign do_step = cmd.finish && !sts.is_move && !sts.no_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            pos_ff[a] <= '0; dir_ff[a] <= 1'b1; len_ff[a] <= '0; idx_ff[a] <= '0;
         end
      end else if (cmd.move) begin
         for (int a = 0; a < AXES; a++) begin
            logic [POS_W-1:0]      tgt;
            logic signed [POS_W:0] diff;
            logic [POS_W:0]        mag;
            tgt  = tgt_of(req_ff, a, pos_ff[a]);
            diff = $signed({tgt[POS_W-1], tgt})
                 - $signed({pos_ff[a][POS_W-1], pos_ff[a]});
            mag  = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
            dir_ff[a] <= !diff[POS_W];
            idx_ff[a] <= '0;
            if (mag > (POS_W+1)'(MAX_MOVE)) len_ff[a] <= MAX_LEN;
            else len_ff[a] <= LEN_W'(mag);
         end
      end else if (do_step) begin
         for (int a = 0; a < AXES; a++) begin
            if (32'(ax) == a) begin
               idx_ff[a] <= idx_ff[a] + 1'b1;
               pos_ff[a] <= dir_ff[a] ? pos_ff[a] + 1'b1 : pos_ff[a] - 1'b1;
            end
         end
      end
   end

   // square root, one bit per cycle (restoring)
   logic [RAD_W-1:0] rad_ff;
   logic [RT_W-1:0]  root_ff;
   logic [RT_W+1:0]  rem_ff;
   logic [RC_W-1:0]  rcnt_ff;
   logic [LEN_W-1:0] k;
   assign k = (cur_idx < (cur_len >> 1)) ? cur_idx : cur_len - cur_idx;

   logic [RT_W+1:0] trial;
   logic [RT_W+1:0] rem_sh;
   assign rem_sh = {rem_ff[RT_W-1:0], rad_ff[2*RT_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign sts.sqrt_last = rcnt_ff == RC_W'(RT_W - 1);

   logic [2*RT_W-1:0] rad_mul;
   assign rad_mul = (2*RT_W)'({k, 1'b0}) * (2*RT_W)'(accel_ff);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rad_ff  <= RAD_W'(rad_mul);
         root_ff <= '0;
         rem_ff  <= '0;
         rcnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= rad_ff << 2;
         rcnt_ff <= rcnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RT_W-2:0], 1'b0};
         end
      end
   end

   // frequency and divisor
   logic [16:0] f_ff;
   logic [RT_W:0] f_sum;
   assign f_sum = (RT_W+1)'(f_min_ff) + (RT_W+1)'(root_ff);
   always_ff @(posedge clock) begin
      if (cmd.freq) f_ff <= (f_sum > (RT_W+1)'(f_max_ff)) ? {1'b0, f_max_ff}
                                                            : 17'(f_sum);
   end

   logic [34:0] dvsr_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul) dvsr_ff <= 35'({1'b0, presc_ff} + 17'd1) * 35'({f_ff, 1'b0});
   end

   // divider, one quotient bit per cycle
   logic [31:0] quo_ff;
   logic [31:0] dvd_ff;
   logic [35:0] prem_ff;
   logic [5:0]  dcnt_ff;
   logic [35:0] prem_sh;
   assign prem_sh = {prem_ff[34:0], dvd_ff[31]};
   assign sts.div_last = dcnt_ff == 6'd31;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         dvd_ff  <= tclk_ff;
         prem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= dvd_ff << 1;
         dcnt_ff <= dcnt_ff + 1'b1;
         if (prem_sh >= {1'b0, dvsr_ff}) begin
            prem_ff <= prem_sh - {1'b0, dvsr_ff};
            quo_ff  <= {quo_ff[30:0], 1'b1};
         end else begin
            prem_ff <= prem_sh;
            quo_ff  <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   logic [15:0] period;
   always_comb begin
      if (dvsr_ff == '0) period = 16'hFFFF;
      else if (quo_ff == '0) period = '0;
      else if ((quo_ff - 32'd1) > 32'h0000FFFF) period = 16'hFFFF;
      else period = 16'(quo_ff - 32'd1);
   end

   // result register; position/direction are read after the update lands
   rsp_type rsp_ff;
   logic    res_step_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_step_ff <= do_step;
         rsp_ff.axis_out      <= sts.is_move ? 2'd0 : ax;
         rsp_ff.step_period   <= do_step ? period : 16'd0;
         rsp_ff.step_valid    <= do_step;
         rsp_ff.move_done     <= !sts.is_move && sts.no_step;
         rsp_ff.direction_out <= 1'b0;
         rsp_ff.position_out  <= '0;
      end
   end

   always_comb begin
      rsp_data = rsp_ff;
      if (rsp_ff.axis_out == 2'd0 || 32'(rsp_ff.axis_out) < AXES) begin
         rsp_data.direction_out = sts.is_move ? dir_ff[0] : cur_dir;
         rsp_data.position_out  = sts.is_move ? pos_ff[0] : cur_pos;
      end else begin
         rsp_data.direction_out = 1'b0;
         rsp_data.position_out  = '0;
      end
      if (!res_step_ff && !sts.is_move && !in_range) begin
         rsp_data.direction_out = 1'b0;
         rsp_data.position_out  = '0;
      end
   end

endmodule

FILE: rtl/stepper_ramp_profile_generator.sv
// Three-axis stepper ramp generator, top level. A move or a finished tick passes through
// the DECODE, FINISH and OUT states; a tick with a step passes through DECODE, SQRT
// (RT_W=18 root bits at defaults), FREQ, MUL, DIV (32 divider bits), FINISH and OUT. One
// item at a time: the next item is taken in the cycle after the result leaves.
// Reset: synchronous, active high; registers take defaults, positions 0, forward.
// Depends on srpg_pkg, srpg_ctrl, srpg_dp.
module stepper_ramp_profile_generator import srpg_pkg::*; #(
   parameter int unsigned AXES     = 3,
   parameter int unsigned MAX_MOVE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   srpg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   srpg_dp #(.AXES(AXES), .MAX_MOVE(MAX_MOVE)) u_dp (
      .clock, .reset, .req_data, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .cmd, .sts, .rsp_data
   );

endmodule
